// ----- hdl/sm83_alu_with_flags_defines.svh -----
// Assertion macros used by the SM83 ALU pipeline module sm83_alu_with_flags.
// Files that assert include this header; it depends on nothing else.
`ifndef SM83_ALU_WITH_FLAGS_DEFINES_SVH
`define SM83_ALU_WITH_FLAGS_DEFINES_SVH

// Checked only while the block is out of reset.
`define SM83ALU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define SM83ALU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- hdl/sm83alu_pkg.sv -----
// Types and constants of the SM83 ALU: operation kinds, flag positions,
// prefixed opcode groups and the request and result structs. No dependencies.
package sm83alu_pkg;

  localparam int unsigned KindW = 5;
  localparam int unsigned DataW = 16;
  localparam int unsigned FlagW = 4;

  localparam int unsigned FlagZ = 3;
  localparam int unsigned FlagN = 2;
  localparam int unsigned FlagH = 1;
  localparam int unsigned FlagC = 0;

  localparam logic [7:0] DaaLimit  = 8'h99;
  localparam logic [7:0] DaaAdjLo  = 8'h06;
  localparam logic [7:0] DaaAdjHi  = 8'h60;
  localparam logic [3:0] DaaNibble = 4'h9;

  typedef enum logic [KindW-1:0] {
    KIND_ADD    = 5'd0,
    KIND_ADC    = 5'd1,
    KIND_SUB    = 5'd2,
    KIND_SBC    = 5'd3,
    KIND_AND    = 5'd4,
    KIND_XOR    = 5'd5,
    KIND_OR     = 5'd6,
    KIND_CP     = 5'd7,
    KIND_INC8   = 5'd8,
    KIND_DEC8   = 5'd9,
    KIND_RLCA   = 5'd10,
    KIND_RRCA   = 5'd11,
    KIND_RLA    = 5'd12,
    KIND_RRA    = 5'd13,
    KIND_DAA    = 5'd14,
    KIND_CPL    = 5'd15,
    KIND_SCF    = 5'd16,
    KIND_CCF    = 5'd17,
    KIND_ADD16  = 5'd18,
    KIND_ADDSP  = 5'd19,
    KIND_INC16  = 5'd20,
    KIND_DEC16  = 5'd21,
    KIND_PREFIX = 5'd22
  } kind_e;

  typedef enum logic [1:0] {
    GRP_SHIFT = 2'd0,
    GRP_BIT   = 2'd1,
    GRP_RES   = 2'd2,
    GRP_SET   = 2'd3
  } grp_e;

  typedef enum logic [2:0] {
    SH_RLC  = 3'd0,
    SH_RRC  = 3'd1,
    SH_RL   = 3'd2,
    SH_RR   = 3'd3,
    SH_SLA  = 3'd4,
    SH_SRA  = 3'd5,
    SH_SWAP = 3'd6,
    SH_SRL  = 3'd7
  } shift_e;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [DataW-1:0] operand_a;
    logic [DataW-1:0] operand_b;
    logic [FlagW-1:0] flags_in;
  } alu_req_t;

  typedef struct packed {
    logic [DataW-1:0] result;
    logic [FlagW-1:0] flags_out;
    logic             writes_result;
  } alu_res_t;

endpackage

// ----- hdl/sm83alu_in_if.sv -----
// Input channel of the SM83 ALU: valid/ready handshake and operation payload.
// Depends on sm83alu_pkg for field widths.
interface sm83alu_in_if;
  logic                              valid;
  logic                              ready;
  logic [sm83alu_pkg::KindW-1:0]     kind;
  logic [sm83alu_pkg::DataW-1:0]     operand_a;
  logic [sm83alu_pkg::DataW-1:0]     operand_b;
  logic [sm83alu_pkg::FlagW-1:0]     flags_in;

  modport source (output valid, kind, operand_a, operand_b, flags_in, input ready);
  modport sink   (input valid, kind, operand_a, operand_b, flags_in, output ready);
endinterface

// ----- hdl/sm83alu_out_if.sv -----
// Output channel of the SM83 ALU: valid/ready handshake and result payload.
// Depends on sm83alu_pkg for field widths.
interface sm83alu_out_if;
  logic                              valid;
  logic                              ready;
  logic [sm83alu_pkg::DataW-1:0]     result;
  logic [sm83alu_pkg::FlagW-1:0]     flags_out;
  logic                              writes_result;

  modport source (output valid, result, flags_out, writes_result, input ready);
  modport sink   (input valid, result, flags_out, writes_result, output ready);
endinterface

// ----- hdl/sm83alu_core.sv -----
// Combinational datapath of the SM83 ALU: computes value, flags and write enable.
// Depends on sm83alu_pkg.
module sm83alu_core (
  input  sm83alu_pkg::alu_req_t req_i,
  output sm83alu_pkg::alu_res_t res_o
);

  logic [7:0]  a8;
  logic [7:0]  b8;
  logic [15:0] a16;
  logic [15:0] b16;
  logic        fz;
  logic        fn;
  logic        fh;
  logic        fc;
  logic        cin;
  logic [8:0]  sum9;
  logic [4:0]  sum_lo;
  logic [8:0]  dif9;
  logic [4:0]  dif_lo;
  logic [7:0]  inc8;
  logic [7:0]  dec8;
  logic [7:0]  daa_adj;
  logic        daa_c;
  logic [7:0]  daa_r;
  logic [16:0] add16;
  logic [12:0] add16_lo;
  logic [15:0] sp_r;
  logic [4:0]  sp_lo;
  logic [8:0]  sp_mid;
  logic [1:0]  grp;
  logic [2:0]  sel;
  logic [7:0]  mask;
  logic [7:0]  sh_r;
  logic        sh_c;
  logic [15:0] r;
  logic        z;
  logic        n;
  logic        h;
  logic        c;
  logic        wr;

  assign a8  = req_i.operand_a[7:0];
  assign b8  = req_i.operand_b[7:0];
  assign a16 = req_i.operand_a;
  assign b16 = req_i.operand_b;
  assign fz  = req_i.flags_in[sm83alu_pkg::FlagZ];
  assign fn  = req_i.flags_in[sm83alu_pkg::FlagN];
  assign fh  = req_i.flags_in[sm83alu_pkg::FlagH];
  assign fc  = req_i.flags_in[sm83alu_pkg::FlagC];

  assign cin = ((req_i.kind == sm83alu_pkg::KIND_ADC) ||
                (req_i.kind == sm83alu_pkg::KIND_SBC)) ? fc : 1'b0;

  assign sum9   = {1'b0, a8} + {1'b0, b8} + {8'd0, cin};
  assign sum_lo = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'd0, cin};
  assign dif9   = {1'b0, a8} - {1'b0, b8} - {8'd0, cin};
  assign dif_lo = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'd0, cin};
  assign inc8   = a8 + 8'd1;
  assign dec8   = a8 - 8'd1;

  always_comb begin
    daa_adj = 8'd0;
    daa_c   = 1'b0;
    if (fh || (!fn && (a8[3:0] > sm83alu_pkg::DaaNibble))) begin
      daa_adj = sm83alu_pkg::DaaAdjLo;
    end
    if (fc || (!fn && (a8 > sm83alu_pkg::DaaLimit))) begin
      daa_adj = daa_adj | sm83alu_pkg::DaaAdjHi;
      daa_c   = 1'b1;
    end
  end
  assign daa_r = fn ? (a8 - daa_adj) : (a8 + daa_adj);

  assign add16    = {1'b0, a16} + {1'b0, b16};
  assign add16_lo = {1'b0, a16[11:0]} + {1'b0, b16[11:0]};
  assign sp_r     = a16 + {{8{b8[7]}}, b8};
  assign sp_lo    = {1'b0, a16[3:0]} + {1'b0, b8[3:0]};
  assign sp_mid   = {1'b0, a16[7:0]} + {1'b0, b8};

  assign grp  = b8[7:6];
  assign sel  = b8[5:3];
  assign mask = 8'd1 << sel;

  always_comb begin
    case (sel)
      sm83alu_pkg::SH_RLC:  begin sh_r = {a8[6:0], a8[7]}; sh_c = a8[7]; end
      sm83alu_pkg::SH_RRC:  begin sh_r = {a8[0], a8[7:1]}; sh_c = a8[0]; end
      sm83alu_pkg::SH_RL:   begin sh_r = {a8[6:0], fc};    sh_c = a8[7]; end
      sm83alu_pkg::SH_RR:   begin sh_r = {fc, a8[7:1]};    sh_c = a8[0]; end
      sm83alu_pkg::SH_SLA:  begin sh_r = {a8[6:0], 1'b0};  sh_c = a8[7]; end
      sm83alu_pkg::SH_SRA:  begin sh_r = {a8[7], a8[7:1]}; sh_c = a8[0]; end
      sm83alu_pkg::SH_SWAP: begin sh_r = {a8[3:0], a8[7:4]}; sh_c = 1'b0; end
      default:              begin sh_r = {1'b0, a8[7:1]};  sh_c = a8[0]; end
    endcase
  end

  always_comb begin
    r  = a16;
    z  = fz;
    n  = fn;
    h  = fh;
    c  = fc;
    wr = 1'b1;
    case (req_i.kind)
      sm83alu_pkg::KIND_ADD, sm83alu_pkg::KIND_ADC: begin
        r = {8'd0, sum9[7:0]};
        z = (sum9[7:0] == 8'd0); n = 1'b0; h = sum_lo[4]; c = sum9[8];
      end
      sm83alu_pkg::KIND_SUB, sm83alu_pkg::KIND_SBC: begin
        r = {8'd0, dif9[7:0]};
        z = (dif9[7:0] == 8'd0); n = 1'b1; h = dif_lo[4]; c = dif9[8];
      end
      sm83alu_pkg::KIND_CP: begin
        r = {8'd0, a8}; wr = 1'b0;
        z = (dif9[7:0] == 8'd0); n = 1'b1; h = dif_lo[4]; c = dif9[8];
      end
      sm83alu_pkg::KIND_AND: begin
        r = {8'd0, a8 & b8};
        z = ((a8 & b8) == 8'd0); n = 1'b0; h = 1'b1; c = 1'b0;
      end
      sm83alu_pkg::KIND_XOR: begin
        r = {8'd0, a8 ^ b8};
        z = ((a8 ^ b8) == 8'd0); n = 1'b0; h = 1'b0; c = 1'b0;
      end
      sm83alu_pkg::KIND_OR: begin
        r = {8'd0, a8 | b8};
        z = ((a8 | b8) == 8'd0); n = 1'b0; h = 1'b0; c = 1'b0;
      end
      sm83alu_pkg::KIND_INC8: begin
        r = {8'd0, inc8};
        z = (inc8 == 8'd0); n = 1'b0; h = (inc8[3:0] == 4'h0);
      end
      sm83alu_pkg::KIND_DEC8: begin
        r = {8'd0, dec8};
        z = (dec8 == 8'd0); n = 1'b1; h = (dec8[3:0] == 4'hF);
      end
      sm83alu_pkg::KIND_RLCA: begin
        r = {8'd0, a8[6:0], a8[7]};
        z = 1'b0; n = 1'b0; h = 1'b0; c = a8[7];
      end
      sm83alu_pkg::KIND_RRCA: begin
        r = {8'd0, a8[0], a8[7:1]};
        z = 1'b0; n = 1'b0; h = 1'b0; c = a8[0];
      end
      sm83alu_pkg::KIND_RLA: begin
        r = {8'd0, a8[6:0], fc};
        z = 1'b0; n = 1'b0; h = 1'b0; c = a8[7];
      end
      sm83alu_pkg::KIND_RRA: begin
        r = {8'd0, fc, a8[7:1]};
        z = 1'b0; n = 1'b0; h = 1'b0; c = a8[0];
      end
      sm83alu_pkg::KIND_DAA: begin
        r = {8'd0, daa_r};
        z = (daa_r == 8'd0); h = 1'b0; c = daa_c;
      end
      sm83alu_pkg::KIND_CPL: begin
        r = {8'd0, ~a8};
        n = 1'b1; h = 1'b1;
      end
      sm83alu_pkg::KIND_SCF: begin
        r = {8'd0, a8}; wr = 1'b0;
        n = 1'b0; h = 1'b0; c = 1'b1;
      end
      sm83alu_pkg::KIND_CCF: begin
        r = {8'd0, a8}; wr = 1'b0;
        n = 1'b0; h = 1'b0; c = !fc;
      end
      sm83alu_pkg::KIND_ADD16: begin
        r = add16[15:0];
        n = 1'b0; h = add16_lo[12]; c = add16[16];
      end
      sm83alu_pkg::KIND_ADDSP: begin
        r = sp_r;
        z = 1'b0; n = 1'b0; h = sp_lo[4]; c = sp_mid[8];
      end
      sm83alu_pkg::KIND_INC16: begin
        r = a16 + 16'd1;
      end
      sm83alu_pkg::KIND_DEC16: begin
        r = a16 - 16'd1;
      end
      sm83alu_pkg::KIND_PREFIX: begin
        case (grp)
          sm83alu_pkg::GRP_BIT: begin
            r = {8'd0, a8}; wr = 1'b0;
            z = ((a8 & mask) == 8'd0); n = 1'b0; h = 1'b1;
          end
          sm83alu_pkg::GRP_RES: begin
            r = {8'd0, a8 & ~mask};
          end
          sm83alu_pkg::GRP_SET: begin
            r = {8'd0, a8 | mask};
          end
          default: begin
            r = {8'd0, sh_r};
            z = (sh_r == 8'd0); n = 1'b0; h = 1'b0; c = sh_c;
          end
        endcase
      end
      default: begin
        wr = 1'b0;
      end
    endcase
  end

  assign res_o.result        = r;
  assign res_o.flags_out     = {z, n, h, c};
  assign res_o.writes_result = wr;

endmodule

// ----- hdl/sm83_alu_with_flags.sv -----
// SM83 ALU with flags: one operation per transfer on the input channel gives
// one result transfer once it has passed the input and result registers. Every
// cycle a new operation can be taken, since the input register, the single
// combinational ALU pass and the result register form a two-stage pipeline
// that only stalls while the output is held back. Depends on sm83alu_pkg, the
// channel interfaces, sm83alu_core and the assertion macro header.
`include "sm83_alu_with_flags_defines.svh"

module sm83_alu_with_flags (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  sm83alu_in_if.sink           in_i,
  sm83alu_out_if.source        out_o
);

  logic                  s1_v_q;
  logic                  s1_v_d;
  sm83alu_pkg::alu_req_t s1_req_q;
  logic                  s2_v_q;
  logic                  s2_v_d;
  sm83alu_pkg::alu_res_t s2_res_q;
  sm83alu_pkg::alu_res_t core_res;
  logic                  s2_ready;
  logic                  s1_adv;
  logic                  in_acc;

  assign s2_ready   = !s2_v_q || out_o.ready;
  assign s1_adv     = s1_v_q && s2_ready;
  assign in_i.ready = !s1_v_q || s2_ready;
  assign in_acc     = in_i.valid && in_i.ready;

  assign s1_v_d = in_i.ready ? in_i.valid : s1_v_q;
  assign s2_v_d = s2_ready ? s1_v_q : s2_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
      s2_v_q <= s2_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_req_q.kind      <= in_i.kind;
      s1_req_q.operand_a <= in_i.operand_a;
      s1_req_q.operand_b <= in_i.operand_b;
      s1_req_q.flags_in  <= in_i.flags_in;
    end
    if (s1_adv) begin
      s2_res_q <= core_res;
    end
  end

  sm83alu_core u_core (
    .req_i (s1_req_q),
    .res_o (core_res)
  );

  assign out_o.valid         = s2_v_q;
  assign out_o.result        = s2_res_q.result;
  assign out_o.flags_out     = s2_res_q.flags_out;
  assign out_o.writes_result = s2_res_q.writes_result;

  `SM83ALU_ASSERT(a_in_captured, in_acc |=> s1_v_q, "accepted transfer not held in input stage")
  `SM83ALU_ASSERT(a_stage_moves, s1_adv |=> s2_v_q, "input stage did not reach result register")
  `SM83ALU_ASSERT(a_s1_holds, (s1_v_q && !s2_ready) |=> (s1_v_q && $stable(s1_req_q)), "stalled input stage lost its operation")
  `SM83ALU_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> (!s1_v_q && !s2_v_q), "pipeline not empty after reset")

endmodule

// ----- sim/tb_sm83_alu_with_flags.sv -----
// Self-checking testbench for sm83_alu_with_flags: directed and random operations over
// every kind, prefixed group and undefined kind code, with random stalls on both channels.
// Depends on sm83alu_pkg, sm83alu_in_if, sm83alu_out_if and the block itself.
module tb_sm83_alu_with_flags;

  localparam int unsigned RandomOps = 1050;
  localparam int unsigned RunLimit  = 4_000_000;

  class alu_outcome_board;
    sm83alu_pkg::alu_res_t pending[$];
    int unsigned           errors;
    int unsigned           checked;

    function logic [3:0] pack_flags(logic z, logic n, logic h, logic c);
      return {z, n, h, c};
    endfunction

    function sm83alu_pkg::alu_res_t predict_alu_op(sm83alu_pkg::alu_req_t req);
      logic [7:0]  a, b, r8, adj, mask;
      logic [15:0] a16, b16;
      logic [8:0]  sum9, sub9;
      logic [4:0]  nib, subnib;
      logic [12:0] sum13;
      logic [16:0] sum17;
      logic        fz, fn, fh, fc, t, cy;
      logic [1:0]  grp;
      logic [2:0]  sel;
      sm83alu_pkg::alu_res_t res;
      a16 = req.operand_a;
      b16 = req.operand_b;
      a = a16[7:0];
      b = b16[7:0];
      fz = req.flags_in[sm83alu_pkg::FlagZ];
      fn = req.flags_in[sm83alu_pkg::FlagN];
      fh = req.flags_in[sm83alu_pkg::FlagH];
      fc = req.flags_in[sm83alu_pkg::FlagC];
      res.result = a16;
      res.flags_out = req.flags_in;
      res.writes_result = 1'b1;
      case (req.kind)
        sm83alu_pkg::KIND_ADD, sm83alu_pkg::KIND_ADC: begin
          t = (req.kind == sm83alu_pkg::KIND_ADC) ? fc : 1'b0;
          sum9 = {1'b0, a} + {1'b0, b} + {8'h00, t};
          nib = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, t};
          res.result = {8'h00, sum9[7:0]};
          res.flags_out = pack_flags(sum9[7:0] == 8'h00, 1'b0, nib[4], sum9[8]);
        end
        sm83alu_pkg::KIND_SUB, sm83alu_pkg::KIND_SBC, sm83alu_pkg::KIND_CP: begin
          t = (req.kind == sm83alu_pkg::KIND_SBC) ? fc : 1'b0;
          r8 = a - b - {7'h00, t};
          subnib = {1'b0, b[3:0]} + {4'h0, t};
          sub9 = {1'b0, b} + {8'h00, t};
          res.flags_out = pack_flags(r8 == 8'h00, 1'b1, {1'b0, a[3:0]} < subnib,
                                     {1'b0, a} < sub9);
          if (req.kind == sm83alu_pkg::KIND_CP) begin
            res.result = {8'h00, a};
            res.writes_result = 1'b0;
          end else begin
            res.result = {8'h00, r8};
          end
        end
        sm83alu_pkg::KIND_AND: begin
          r8 = a & b;
          res.result = {8'h00, r8};
          res.flags_out = pack_flags(r8 == 8'h00, 1'b0, 1'b1, 1'b0);
        end
        sm83alu_pkg::KIND_XOR, sm83alu_pkg::KIND_OR: begin
          r8 = (req.kind == sm83alu_pkg::KIND_XOR) ? (a ^ b) : (a | b);
          res.result = {8'h00, r8};
          res.flags_out = pack_flags(r8 == 8'h00, 1'b0, 1'b0, 1'b0);
        end
        sm83alu_pkg::KIND_INC8: begin
          r8 = a + 8'h01;
          res.result = {8'h00, r8};
          res.flags_out = pack_flags(r8 == 8'h00, 1'b0, r8[3:0] == 4'h0, fc);
        end
        sm83alu_pkg::KIND_DEC8: begin
          r8 = a - 8'h01;
          res.result = {8'h00, r8};
          res.flags_out = pack_flags(r8 == 8'h00, 1'b1, r8[3:0] == 4'hF, fc);
        end
        sm83alu_pkg::KIND_RLCA, sm83alu_pkg::KIND_RRCA, sm83alu_pkg::KIND_RLA,
        sm83alu_pkg::KIND_RRA: begin
          case (req.kind)
            sm83alu_pkg::KIND_RLCA: r8 = {a[6:0], a[7]};
            sm83alu_pkg::KIND_RRCA: r8 = {a[0], a[7:1]};
            sm83alu_pkg::KIND_RLA:  r8 = {a[6:0], fc};
            default:                r8 = {fc, a[7:1]};
          endcase
          cy = (req.kind == sm83alu_pkg::KIND_RLCA || req.kind == sm83alu_pkg::KIND_RLA) ?
               a[7] : a[0];
          res.result = {8'h00, r8};
          res.flags_out = pack_flags(1'b0, 1'b0, 1'b0, cy);
        end
        sm83alu_pkg::KIND_DAA: begin
          adj = 8'h00;
          cy = 1'b0;
          if (fh || (!fn && a[3:0] > 4'h9)) adj = 8'h06;
          if (fc || (!fn && a > 8'h99)) begin
            adj = adj | 8'h60;
            cy = 1'b1;
          end
          r8 = fn ? (a - adj) : (a + adj);
          res.result = {8'h00, r8};
          res.flags_out = pack_flags(r8 == 8'h00, fn, 1'b0, cy);
        end
        sm83alu_pkg::KIND_CPL: begin
          res.result = {8'h00, ~a};
          res.flags_out = pack_flags(fz, 1'b1, 1'b1, fc);
        end
        sm83alu_pkg::KIND_SCF, sm83alu_pkg::KIND_CCF: begin
          res.result = {8'h00, a};
          res.writes_result = 1'b0;
          res.flags_out = pack_flags(fz, 1'b0, 1'b0,
                                     (req.kind == sm83alu_pkg::KIND_SCF) ? 1'b1 : !fc);
        end
        sm83alu_pkg::KIND_ADD16: begin
          sum17 = {1'b0, a16} + {1'b0, b16};
          sum13 = {1'b0, a16[11:0]} + {1'b0, b16[11:0]};
          res.result = sum17[15:0];
          res.flags_out = pack_flags(fz, 1'b0, sum13[12], sum17[16]);
        end
        sm83alu_pkg::KIND_ADDSP: begin
          nib = {1'b0, a16[3:0]} + {1'b0, b[3:0]};
          sum9 = {1'b0, a16[7:0]} + {1'b0, b};
          res.result = a16 + {{8{b[7]}}, b};
          res.flags_out = pack_flags(1'b0, 1'b0, nib[4], sum9[8]);
        end
        sm83alu_pkg::KIND_INC16: res.result = a16 + 16'h0001;
        sm83alu_pkg::KIND_DEC16: res.result = a16 - 16'h0001;
        sm83alu_pkg::KIND_PREFIX: begin
          grp = b[7:6];
          sel = b[5:3];
          mask = 8'h01 << sel;
          case (grp)
            sm83alu_pkg::GRP_BIT: begin
              res.result = {8'h00, a};
              res.writes_result = 1'b0;
              res.flags_out = pack_flags((a & mask) == 8'h00, 1'b0, 1'b1, fc);
            end
            sm83alu_pkg::GRP_RES: res.result = {8'h00, a & ~mask};
            sm83alu_pkg::GRP_SET: res.result = {8'h00, a | mask};
            default: begin
              case (sel)
                sm83alu_pkg::SH_RLC:  begin r8 = {a[6:0], a[7]}; cy = a[7]; end
                sm83alu_pkg::SH_RRC:  begin r8 = {a[0], a[7:1]}; cy = a[0]; end
                sm83alu_pkg::SH_RL:   begin r8 = {a[6:0], fc};   cy = a[7]; end
                sm83alu_pkg::SH_RR:   begin r8 = {fc, a[7:1]};   cy = a[0]; end
                sm83alu_pkg::SH_SLA:  begin r8 = {a[6:0], 1'b0}; cy = a[7]; end
                sm83alu_pkg::SH_SRA:  begin r8 = {a[7], a[7:1]}; cy = a[0]; end
                sm83alu_pkg::SH_SWAP: begin r8 = {a[3:0], a[7:4]}; cy = 1'b0; end
                default:              begin r8 = {1'b0, a[7:1]}; cy = a[0]; end
              endcase
              res.result = {8'h00, r8};
              res.flags_out = pack_flags(r8 == 8'h00, 1'b0, 1'b0, cy);
            end
          endcase
        end
        default: res.writes_result = 1'b0;
      endcase
      return res;
    endfunction

    function void note_op(sm83alu_pkg::alu_req_t req);
      pending.push_back(predict_alu_op(req));
    endfunction

    function void check_result(sm83alu_pkg::alu_res_t got);
      sm83alu_pkg::alu_res_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result transfer, expected none, actual %h/%h/%b", $time,
                 got.result, got.flags_out, got.writes_result);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.result !== want.result) begin
        $display("%0t: result mismatch, expected %h actual %h", $time, want.result,
                 got.result);
        errors++;
      end
      if (got.flags_out !== want.flags_out) begin
        $display("%0t: flags_out mismatch, expected %b actual %b", $time, want.flags_out,
                 got.flags_out);
        errors++;
      end
      if (got.writes_result !== want.writes_result) begin
        $display("%0t: writes_result mismatch, expected %b actual %b", $time,
                 want.writes_result, got.writes_result);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   steady_phase;

  sm83alu_in_if  in_bus ();
  sm83alu_out_if out_bus ();

  alu_outcome_board outcomes = new();

  sm83_alu_with_flags i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    steady_phase = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.kind = '0;
    in_bus.operand_a = '0;
    in_bus.operand_b = '0;
    in_bus.flags_in = '0;
    out_bus.ready = 1'b0;
  end

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_bus.ready <= steady_phase ? 1'b1 : ($urandom_range(99) >= 35);
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      sm83alu_pkg::alu_res_t got;
      got.result = out_bus.result;
      got.flags_out = out_bus.flags_out;
      got.writes_result = out_bus.writes_result;
      outcomes.check_result(got);
    end
  end

  function automatic sm83alu_pkg::alu_req_t make_op(logic [4:0] kind, logic [15:0] a,
                                                    logic [15:0] b, logic [3:0] f);
    sm83alu_pkg::alu_req_t req;
    req.kind = kind;
    req.operand_a = a;
    req.operand_b = b;
    req.flags_in = f;
    return req;
  endfunction

  function automatic logic [15:0] pick_operand();
    logic [15:0] hi;
    hi = 16'($urandom_range(255)) << 8;
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return hi | 16'h00FF;
      3: return hi | 16'h0000;
      4: return hi | 16'h000F;
      5: return hi | 16'h0099;
      6: return hi | 16'h0080;
      7: return 16'h0FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic sm83alu_pkg::alu_req_t make_random_op();
    logic [4:0] kind;
    if ($urandom_range(99) < 5) kind = 5'($urandom_range(31, 23));
    else kind = 5'($urandom_range(22, 0));
    return make_op(kind, pick_operand(), pick_operand(), 4'($urandom_range(15)));
  endfunction

  task automatic send_op(input sm83alu_pkg::alu_req_t req);
    int unsigned gaps;
    gaps = 0;
    while (!steady_phase && $urandom_range(99) < 35) gaps++;
    if (gaps > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gaps) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.kind <= req.kind;
    in_bus.operand_a <= req.operand_a;
    in_bus.operand_b <= req.operand_b;
    in_bus.flags_in <= req.flags_in;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    outcomes.note_op(req);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_op(make_op(sm83alu_pkg::KIND_ADD,    16'hFFFF, 16'hFF01, 4'h0));
    send_op(make_op(sm83alu_pkg::KIND_ADC,    16'h000F, 16'h0000, 4'h1));
    send_op(make_op(sm83alu_pkg::KIND_ADC,    16'h00FF, 16'hFFFF, 4'hF));
    send_op(make_op(sm83alu_pkg::KIND_SUB,    16'h0042, 16'h0042, 4'h0));
    send_op(make_op(sm83alu_pkg::KIND_SBC,    16'h0000, 16'h0000, 4'h1));
    send_op(make_op(sm83alu_pkg::KIND_SBC,    16'h0010, 16'h000F, 4'h1));
    send_op(make_op(sm83alu_pkg::KIND_CP,     16'h0010, 16'h0020, 4'h0));
    send_op(make_op(sm83alu_pkg::KIND_AND,    16'h00F0, 16'h000F, 4'hF));
    send_op(make_op(sm83alu_pkg::KIND_XOR,    16'h00A5, 16'h00A5, 4'hF));
    send_op(make_op(sm83alu_pkg::KIND_OR,     16'h0000, 16'h0080, 4'h0));
    send_op(make_op(sm83alu_pkg::KIND_INC8,   16'h00FF, 16'h0000, 4'h1));
    send_op(make_op(sm83alu_pkg::KIND_DEC8,   16'h0010, 16'h0000, 4'h0));
    send_op(make_op(sm83alu_pkg::KIND_DEC8,   16'h0001, 16'h0000, 4'h1));
    send_op(make_op(sm83alu_pkg::KIND_RLCA,   16'h0080, 16'h0000, 4'hF));
    send_op(make_op(sm83alu_pkg::KIND_RRCA,   16'h0001, 16'h0000, 4'h0));
    send_op(make_op(sm83alu_pkg::KIND_RLA,    16'h0080, 16'h0000, 4'h1));
    send_op(make_op(sm83alu_pkg::KIND_RRA,    16'h0001, 16'h0000, 4'h1));
    send_op(make_op(sm83alu_pkg::KIND_DAA,    16'h009A, 16'h0000, 4'h0));
    send_op(make_op(sm83alu_pkg::KIND_DAA,    16'h0000, 16'h0000, 4'h7));
    send_op(make_op(sm83alu_pkg::KIND_CPL,    16'h0000, 16'h0000, 4'h8));
    send_op(make_op(sm83alu_pkg::KIND_SCF,    16'hFFFF, 16'h0000, 4'h6));
    send_op(make_op(sm83alu_pkg::KIND_CCF,    16'h1234, 16'h0000, 4'hF));
    send_op(make_op(sm83alu_pkg::KIND_ADD16,  16'hFFFF, 16'h0001, 4'h0));
    send_op(make_op(sm83alu_pkg::KIND_ADD16,  16'h0FFF, 16'h0001, 4'h8));
    send_op(make_op(sm83alu_pkg::KIND_ADDSP,  16'hFFFF, 16'h0080, 4'hF));
    send_op(make_op(sm83alu_pkg::KIND_INC16,  16'hFFFF, 16'h0000, 4'h5));
    send_op(make_op(sm83alu_pkg::KIND_DEC16,  16'h0000, 16'h0000, 4'hA));
    send_op(make_op(sm83alu_pkg::KIND_PREFIX, 16'h0000, 16'h007F, 4'h0));
    send_op(make_op(5'd31,                    16'hFFFF, 16'hFFFF, 4'hF));

    for (int unsigned n = 0; n < RandomOps; n++) begin
      steady_phase = (n >= 400 && n < 600);
      send_op(make_random_op());
    end
    steady_phase = 1'b0;
    in_bus.valid <= 1'b0;

    while (outcomes.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Checked %0d results across all operation kinds, undefined kind codes and",
             outcomes.checked);
    $display("every prefixed group, with random stalls on both channels.");
    if (outcomes.errors == 0) begin
      $display("** sm83_alu_with_flags: PASSED **");
    end else begin
      $display("** sm83_alu_with_flags: FAILED **");
    end
    $finish;
  end

  initial begin
    #(RunLimit);
    $display("Timeout while waiting for transfers.");
    $display("** sm83_alu_with_flags: FAILED **");
    $finish;
  end
endmodule
